// ===== hw/rtl/conv3x3_rgb_reflect_clamp_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CONV3X3_RGB_REFLECT_CLAMP_MACROS_SVH
`define CONV3X3_RGB_REFLECT_CLAMP_MACROS_SVH

// Clocked check, switched off while reset is high
`define CVR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset
`define CVR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/cvr_pkg.sv =====
`default_nettype none

package cvr_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int CHANNEL_BITS = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SIZE_W  = 12;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 3;
  localparam int COEF_W  = 16;
  localparam int BANKS   = 4;
  localparam int BANK_W  = 2;
  localparam int CHANS   = 3;

  // Arithmetic widths: coef x {0,pixel}, then a three-term and a nine-term sum
  localparam int PROD_W   = COEF_W + CHANNEL_BITS + 1;
  localparam int ROWSUM_W = PROD_W + 2;
  localparam int SUM_W    = PROD_W + 4;
  localparam int FRAC_W   = 8;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Channel order inside a pixel
  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;

  // Input word kinds
  localparam logic MODE_PIXEL = 1'b0;

  // Register indexes
  typedef logic [IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_WIDTH    = 3'd0;
  localparam reg_idx_t REG_HEIGHT   = 3'd1;
  localparam reg_idx_t REG_COEF_TOP = 3'd2;
  localparam reg_idx_t REG_COEF_MID = 3'd3;
  localparam reg_idx_t REG_COEF_BOT = 3'd4;

  typedef logic [SIZE_W-1:0] size_t;
  localparam size_t WIDTH_RESET  = 12'd640;
  localparam size_t HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] COEF_TOP_RESET = 48'h0;
  localparam logic [CFG_W-1:0] COEF_MID_RESET = 48'h0000_0100_0000;
  localparam logic [CFG_W-1:0] COEF_BOT_RESET = 48'h0;

  typedef logic [CHANS-1:0][CHANNEL_BITS-1:0] pix_t;
  // One column of the window: index 0 upper row, 1 centre, 2 lower
  typedef pix_t [2:0] col_t;
  // Window: index 0 left column, 1 centre, 2 right
  typedef col_t [2:0] win_t;
  // One line-RAM word: the same column of all four banked rows
  typedef pix_t [BANKS-1:0] bank_word_t;
  // Kernel rows, index 0 top
  typedef logic [2:0][CFG_W-1:0] coef_set_t;

  // Control handed from the sequencer to the window stage
  typedef struct packed {
    logic              emit;
    logic              fetch;
    logic              rowstart;
    logic              first_col;
    logic              last_col;
    logic              frame_last;
    logic [BANK_W-1:0] bank_up;
    logic [BANK_W-1:0] bank_mid;
    logic [BANK_W-1:0] bank_dn;
    logic              fwd_up;
    logic              fwd_mid;
    logic              fwd_dn;
    pix_t              fwd_pix;
  } fetch_ctl_t;

  typedef struct packed {
    pix_t pix;
    logic last;
  } out_word_t;

  // Size register write: below 2 reads as 2, above the maximum as the maximum
  function automatic size_t clamp_size(input size_t v, input size_t maxv);
    size_t r;
    if (v < size_t'(2)) r = size_t'(2);
    else if (v > maxv)  r = maxv;
    else                r = v;
    return r;
  endfunction

  // Round half up, drop the fraction, clamp to the channel range
  function automatic logic [CHANNEL_BITS-1:0] finish(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] t;
    logic [CHANNEL_BITS-1:0] r;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(128);
    if (t[SUM_W])                                     r = '0;
    else if (|t[SUM_W-1:FRAC_W+CHANNEL_BITS])         r = '1;
    else                                              r = t[FRAC_W+CHANNEL_BITS-1:FRAC_W];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cvr_line_ram.sv =====
`default_nettype none

// Line store: one word per column holds that column of four rows (row mod 4).
// Each write updates one lane; one registered read per cycle.
module cvr_line_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [cvr_pkg::BANK_W-1:0]    wr_lane,
  input  logic [cvr_pkg::COL_W-1:0]     wr_addr,
  input  cvr_pkg::pix_t                 wr_data,
  input  logic [cvr_pkg::COL_W-1:0]     rd_addr,
  output cvr_pkg::bank_word_t           rd_data
);
  import cvr_pkg::*;

  bank_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr][wr_lane] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cvr_ctrl.sv =====
`default_nettype none

// Registers, position counters and fetch sequencing.
module cvr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  cvr_pkg::reg_idx_t             cfg_index,
  input  logic [cvr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic                          mode,
  input  cvr_pkg::pix_t                 in_pix,
  output logic                          wr_en,
  output logic [cvr_pkg::BANK_W-1:0]    wr_bank,
  output logic [cvr_pkg::COL_W-1:0]     wr_col,
  output cvr_pkg::pix_t                 wr_pix,
  output logic [cvr_pkg::COL_W-1:0]     rd_col,
  output cvr_pkg::fetch_ctl_t           s1,
  output cvr_pkg::coef_set_t            coefs
);
  import cvr_pkg::*;

  size_t              frame_width;
  size_t              frame_height;
  logic [COL_W-1:0]   in_column;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   out_column;
  logic [ROW_W-1:0]   out_row;
  logic               in_done;
  size_t              lag;          // pixels in minus results out

  logic               pix_ok;
  logic               emit;
  logic               in_col_last;
  logic               in_row_last;
  logic               out_col_last;
  logic               out_row_last;
  logic               prefetch;
  logic [ROW_W-1:0]   fetch_row;
  logic [COL_W-1:0]   fetch_col;
  logic [ROW_W-1:0]   row_up;
  logic [ROW_W-1:0]   row_dn;
  logic               fwd_hit;
  logic               size_write;
  fetch_ctl_t         s1_next;

  // Word classification
  always_comb begin
    pix_ok       = accept && (mode == MODE_PIXEL) && !in_done;
    emit         = (pix_ok && ((SIZE_W+1)'(lag) >= (SIZE_W+1)'(frame_width) + (SIZE_W+1)'(1)))
                || (accept && !pix_ok && in_done);
    in_col_last  = size_t'(in_column)  == frame_width  - size_t'(1);
    in_row_last  = size_t'(in_row)     == frame_height - size_t'(1);
    out_col_last = size_t'(out_column) == frame_width  - size_t'(1);
    out_row_last = size_t'(out_row)    == frame_height - size_t'(1);
    prefetch     = pix_ok && (in_column == '0) && (in_row == ROW_W'(1));
    size_write   = cfg_we && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));
  end

  // Which column to fetch next and from which rows (reflect at the frame edge)
  always_comb begin
    priority if (prefetch) begin
      fetch_row = '0;
      fetch_col = '0;
    end else if (out_col_last) begin
      fetch_row = out_row + ROW_W'(1);
      fetch_col = '0;
    end else begin
      fetch_row = out_row;
      fetch_col = out_column + COL_W'(1);
    end
    row_up = (fetch_row == '0) ? ROW_W'(1) : fetch_row - ROW_W'(1);
    row_dn = (size_t'(fetch_row) + size_t'(1) == frame_height)
           ? ROW_W'(frame_height - size_t'(2)) : fetch_row + ROW_W'(1);
    fwd_hit = pix_ok && (fetch_col == in_column);

    s1_next.emit       = emit;
    s1_next.fetch      = prefetch || (emit && !(out_col_last && out_row_last));
    s1_next.rowstart   = prefetch || (emit && out_col_last);
    s1_next.first_col  = out_column == '0;
    s1_next.last_col   = out_col_last;
    s1_next.frame_last = out_col_last && out_row_last;
    s1_next.bank_up    = row_up[BANK_W-1:0];
    s1_next.bank_mid   = fetch_row[BANK_W-1:0];
    s1_next.bank_dn    = row_dn[BANK_W-1:0];
    s1_next.fwd_up     = fwd_hit && (row_up[BANK_W-1:0]    == in_row[BANK_W-1:0]);
    s1_next.fwd_mid    = fwd_hit && (fetch_row[BANK_W-1:0] == in_row[BANK_W-1:0]);
    s1_next.fwd_dn     = fwd_hit && (row_dn[BANK_W-1:0]    == in_row[BANK_W-1:0]);
    s1_next.fwd_pix    = in_pix;
  end

  assign wr_en   = pix_ok;
  assign wr_bank = in_row[BANK_W-1:0];
  assign wr_col  = in_column;
  assign wr_pix  = in_pix;
  assign rd_col  = fetch_col;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      coefs[0]     <= COEF_TOP_RESET;
      coefs[1]     <= COEF_MID_RESET;
      coefs[2]     <= COEF_BOT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:    frame_width  <= clamp_size(cfg_data[SIZE_W-1:0], size_t'(MAX_WIDTH));
        REG_HEIGHT:   frame_height <= clamp_size(cfg_data[SIZE_W-1:0], size_t'(MAX_HEIGHT));
        REG_COEF_TOP: coefs[0]     <= cfg_data;
        REG_COEF_MID: coefs[1]     <= cfg_data;
        REG_COEF_BOT: coefs[2]     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position counters
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      in_done    <= 1'b0;
      lag        <= '0;
    end else if (accept) begin
      if (emit && s1_next.frame_last) begin
        // last result of the frame: start over
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
        in_done    <= 1'b0;
        lag        <= '0;
      end else begin
        if (pix_ok) begin
          if (in_col_last) begin
            in_column <= '0;
            in_row    <= in_row + ROW_W'(1);
            if (in_row_last) begin
              in_done <= 1'b1;
            end
          end else begin
            in_column <= in_column + COL_W'(1);
          end
        end
        if (pix_ok && !emit) begin
          lag <= lag + size_t'(1);
        end else if (!pix_ok && emit) begin
          lag <= lag - size_t'(1);
        end
        if (emit) begin
          if (out_col_last) begin
            out_column <= '0;
            out_row    <= out_row + ROW_W'(1);
          end else begin
            out_column <= out_column + COL_W'(1);
          end
        end
      end
    end
  end

  // Fetch control into the read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cvr_window.sv =====
`default_nettype none

// Column window: takes the fetched column from the line RAM (or the pixel
// written in the same cycle) and builds the 3x3 window with edge mirroring.
module cvr_window (
  input  logic                  clk,
  input  logic                  rst,
  input  cvr_pkg::fetch_ctl_t   s1,
  input  cvr_pkg::bank_word_t   rd_word,
  output logic                  s2_valid,
  output logic                  s2_last,
  output cvr_pkg::win_t         s2_win
);
  import cvr_pkg::*;

  col_t col_new;
  col_t col_p;      // column before the centre
  col_t col_q;      // centre column
  win_t win;

  // New column, with forwarding of the word written alongside the read
  always_comb begin
    col_new[0] = s1.fwd_up  ? s1.fwd_pix : rd_word[s1.bank_up];
    col_new[1] = s1.fwd_mid ? s1.fwd_pix : rd_word[s1.bank_mid];
    col_new[2] = s1.fwd_dn  ? s1.fwd_pix : rd_word[s1.bank_dn];
  end

  // Left and right mirror each other at the row ends
  always_comb begin
    win[1] = col_q;
    priority if (s1.first_col) begin
      win[0] = col_new;
      win[2] = col_new;
    end else if (s1.last_col) begin
      win[0] = col_p;
      win[2] = col_p;
    end else begin
      win[0] = col_p;
      win[2] = col_new;
    end
  end

  // Column history
  always_ff @(posedge clk) begin
    if (s1.fetch) begin
      if (s1.rowstart) begin
        col_q <= col_new;
      end else begin
        col_p <= col_q;
        col_q <= col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.emit;
    end
    s2_last <= s1.frame_last;
    s2_win  <= win;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cvr_mac.sv =====
`default_nettype none

// Multiply-accumulate: 27 products, row sums, total with rounding and clamp.
module cvr_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s2_valid,
  input  logic                  s2_last,
  input  cvr_pkg::win_t         s2_win,
  input  cvr_pkg::coef_set_t    coefs,
  output logic [1:0]            busy,
  output logic                  push,
  output cvr_pkg::out_word_t    push_word
);
  import cvr_pkg::*;

  logic signed [PROD_W-1:0]   prod [CHANS][3][3];
  logic signed [ROWSUM_W-1:0] rsum [CHANS][3];
  logic signed [SUM_W-1:0]    total [CHANS];
  logic signed [COEF_W-1:0]   coef_k [3][3];
  logic                       s3_valid;
  logic                       s3_last;
  logic                       s4_valid;
  logic                       s4_last;

  // Coefficient words: [dy][dx], left word in the low bits
  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        coef_k[dy][dx] = coefs[dy][dx*COEF_W +: COEF_W];
      end
    end
  end

  // Products
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANS; ch++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          prod[ch][dy][dx] <= coef_k[dy][dx]
                            * $signed({1'b0, s2_win[dx][dy][ch]});
        end
      end
    end
  end

  // Row sums
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < CHANS; ch++) begin
      for (int dy = 0; dy < 3; dy++) begin
        rsum[ch][dy] <= ROWSUM_W'(prod[ch][dy][0]) + ROWSUM_W'(prod[ch][dy][1])
                      + ROWSUM_W'(prod[ch][dy][2]);
      end
    end
  end

  // Total and result word
  always_comb begin
    for (int ch = 0; ch < CHANS; ch++) begin
      total[ch] = SUM_W'(rsum[ch][0]) + SUM_W'(rsum[ch][1]) + SUM_W'(rsum[ch][2]);
      push_word.pix[ch] = finish(total[ch]);
    end
    push_word.last = s4_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s3_last <= s2_last;
    s4_last <= s3_last;
  end

  assign push = s4_valid;
  assign busy = {s4_valid, s3_valid};

endmodule

`default_nettype wire

// ===== hw/rtl/cvr_out_fifo.sv =====
`default_nettype none

// Result queue: absorbs everything in flight when the consumer stalls.
module cvr_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  cvr_pkg::out_word_t            push_word,
  input  logic                          pop,
  output logic                          out_valid,
  output cvr_pkg::out_word_t            head,
  output logic [cvr_pkg::FIFO_CW-1:0]   count
);
  import cvr_pkg::*;

  out_word_t          slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  assign out_valid = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count <= count + FIFO_CW'(1);
      end else if (!push && pop) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/conv3x3_rgb_reflect_clamp.sv =====
`default_nettype none

// 3x3 RGB convolution with mirror-without-repeat borders. Takes one word per
// clock (a pixel, or with mode high a drain tick); output pixel k of a frame
// is released by input pixel k+W+1, and the last W+1 results of a frame by
// drain ticks, one per tick. The rate is set by the line RAM, which serves
// one column read (four rows wide) and one pixel write per clock; the pixel
// being written is forwarded into the column read of the same clock. An
// eight-word result queue lets input continue while results wait; input stalls
// only when the words queued plus those in the four-stage pipeline reach eight.
// The line RAM is not cleared after reset and needs no clearing pass. Write
// frame_width and frame_height only between frames; doing so restarts the
// frame.
module conv3x3_rgb_reflect_clamp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  cvr_pkg::reg_idx_t                     cfg_index,
  input  logic [cvr_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic [cvr_pkg::CHANNEL_BITS-1:0]      pix_blue,
  input  logic [cvr_pkg::CHANNEL_BITS-1:0]      pix_green,
  input  logic [cvr_pkg::CHANNEL_BITS-1:0]      pix_red,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [cvr_pkg::CHANNEL_BITS-1:0]      out_blue,
  output logic [cvr_pkg::CHANNEL_BITS-1:0]      out_green,
  output logic [cvr_pkg::CHANNEL_BITS-1:0]      out_red,
  output logic                                  frame_last
);
  import cvr_pkg::*;

  logic               accept;
  pix_t               in_pix;
  logic               wr_en;
  logic [BANK_W-1:0]  wr_bank;
  logic [COL_W-1:0]   wr_col;
  pix_t               wr_pix;
  logic [COL_W-1:0]   rd_col;
  bank_word_t         rd_word;
  fetch_ctl_t         s1;
  coef_set_t          coefs;
  logic               s2_valid;
  logic               s2_last;
  win_t               s2_win;
  logic [1:0]         mac_busy;
  logic               push;
  out_word_t          push_word;
  out_word_t          head;
  logic [FIFO_CW-1:0] fifo_count;
  logic [FIFO_CW:0]   committed;

  // Room check: queued words plus results still in the pipeline
  always_comb begin
    committed = (FIFO_CW+1)'(fifo_count) + (FIFO_CW+1)'(s1.emit) + (FIFO_CW+1)'(s2_valid)
              + (FIFO_CW+1)'(mac_busy[0]) + (FIFO_CW+1)'(mac_busy[1]);
    in_ready  = committed < (FIFO_CW+1)'(FIFO_DEPTH);
    accept    = in_valid && in_ready;
    in_pix[CH_BLUE]  = pix_blue;
    in_pix[CH_GREEN] = pix_green;
    in_pix[CH_RED]   = pix_red;
  end

  cvr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .mode      (mode),
    .in_pix    (in_pix),
    .wr_en     (wr_en),
    .wr_bank   (wr_bank),
    .wr_col    (wr_col),
    .wr_pix    (wr_pix),
    .rd_col    (rd_col),
    .s1        (s1),
    .coefs     (coefs)
  );

  cvr_line_ram u_ram (
    .clk     (clk),
    .we      (wr_en),
    .wr_lane (wr_bank),
    .wr_addr (wr_col),
    .wr_data (wr_pix),
    .rd_addr (rd_col),
    .rd_data (rd_word)
  );

  cvr_window u_window (
    .clk      (clk),
    .rst      (rst),
    .s1       (s1),
    .rd_word  (rd_word),
    .s2_valid (s2_valid),
    .s2_last  (s2_last),
    .s2_win   (s2_win)
  );

  cvr_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_last   (s2_last),
    .s2_win    (s2_win),
    .coefs     (coefs),
    .busy      (mac_busy),
    .push      (push),
    .push_word (push_word)
  );

  cvr_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (out_valid && out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (fifo_count)
  );

  assign out_blue   = head.pix[CH_BLUE];
  assign out_green  = head.pix[CH_GREEN];
  assign out_red    = head.pix[CH_RED];
  assign frame_last = head.last;

endmodule

`default_nettype wire

// ===== hw/rtl/cvr_checker.sv =====
`default_nettype none

`include "conv3x3_rgb_reflect_clamp_macros.svh"

// Port-level checks on the filter
module cvr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [cvr_pkg::CHANNEL_BITS-1:0]   out_blue,
  input logic [cvr_pkg::CHANNEL_BITS-1:0]   out_green,
  input logic [cvr_pkg::CHANNEL_BITS-1:0]   out_red,
  input logic                               frame_last
);
  import cvr_pkg::*;

  // A stalled result stays offered
  `CVR_ASSERT_CLK(a_out_hold, (out_valid && !out_ready |=> out_valid), "result dropped while stalled")

  // A stalled result keeps its word
  `CVR_ASSERT_CLK(a_out_stable, (out_valid && !out_ready |=> $stable({out_blue, out_green, out_red, frame_last})), "result word changed while stalled")

  // Nothing comes out straight after reset
  `CVR_ASSERT_RST(a_reset_empty, (rst |=> !out_valid), "result offered after reset")

  // A result that starts an output burst was released by an earlier accepted word
  `CVR_ASSERT_CLK(a_latency, ($rose(out_valid) |-> $past(in_valid && in_ready, 5)), "result without a releasing input word")

endmodule

bind conv3x3_rgb_reflect_clamp cvr_checker u_cvr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_blue   (out_blue),
  .out_green  (out_green),
  .out_red    (out_red),
  .frame_last (frame_last)
);

`default_nettype wire

// ===== verif/conv3x3_rgb_reflect_clamp_test.sv =====
`timescale 1ns / 100ps

module conv3x3_rgb_reflect_clamp_test;
  import cvr_pkg::*;

  localparam reg_idx_t REG_SPARE_LO = 3'd5;
  localparam reg_idx_t REG_SPARE_HI = 3'd7;
  localparam logic MODE_DRAIN = ~MODE_PIXEL;
  localparam int SETTLE_CYCLES = 16;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int RANDOM_WORDS = 1500;

  typedef struct {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       last;
  } pix_result_t;

  typedef enum {CHK_MODEL, CHK_TYPED, CHK_NONE} chk_t;

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [47:0] data;
    logic        m;
    logic [7:0]  b, g, r;
    chk_t        chk;
    pix_result_t res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = MODE_PIXEL;
  logic [7:0] pix_blue = '0, pix_green = '0, pix_red = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_blue, out_green, out_red;
  logic frame_last;

  conv3x3_rgb_reflect_clamp uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .pix_blue(pix_blue), .pix_green(pix_green), .pix_red(pix_red),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_blue(out_blue), .out_green(out_green), .out_red(out_red),
    .frame_last(frame_last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Filter state mirror
  logic [7:0] row_mem [4][MAX_WIDTH][3];
  int unsigned fw = 640, fh = 480;
  logic [47:0] kern [3] = '{48'h0, 48'h0000_0100_0000, 48'h0};
  int unsigned icol, irow, ocol, orow;

  pix_result_t pending_pix [$];
  int mismatches = 0;
  longint cycles = 0;
  int words_sent = 0;
  bit quiet_in = 1'b0;

  function automatic int unsigned size_clip(logic [47:0] v);
    int unsigned s;
    s = v[11:0];
    if (s < 2) return 2;
    if (s > MAX_WIDTH) return MAX_WIDTH;
    return s;
  endfunction

  function automatic void model_cfg(reg_idx_t idx, logic [47:0] d);
    case (idx)
      REG_WIDTH: begin
        fw = size_clip(d);
        icol = 0; irow = 0; ocol = 0; orow = 0;
      end
      REG_HEIGHT: begin
        fh = size_clip(d);
        icol = 0; irow = 0; ocol = 0; orow = 0;
      end
      REG_COEF_TOP: kern[0] = d;
      REG_COEF_MID: kern[1] = d;
      REG_COEF_BOT: kern[2] = d;
      default: ;
    endcase
  endfunction

  // Mirror without repeating the edge
  function automatic int unsigned mirror(int unsigned pos, int off, int unsigned size);
    if (off < 0) return (pos == 0) ? 1 : pos - 1;
    if (off > 0) return (pos + 1 >= size) ? size - 2 : pos + 1;
    return pos;
  endfunction

  function automatic logic [7:0] round_clip(longint s);
    longint t;
    t = s + 128;
    if (t < 0) return 8'd0;
    t = t / 256;
    if (t > 255) return 8'd255;
    return t[7:0];
  endfunction

  // Advance the filter by one word; returns 1 when a pixel comes out
  function automatic bit filter_word(logic m, logic [7:0] b, g, r, output pix_result_t res);
    int unsigned total, inc, outc, rr, cc;
    bit emit;
    longint sum [3];
    logic signed [15:0] k;
    emit = 0;
    res = '{8'd0, 8'd0, 8'd0, 1'b0};
    total = fw * fh;
    inc = irow * fw + icol;
    outc = orow * fw + ocol;
    if (m == MODE_PIXEL && inc < total) begin
      row_mem[irow & 3][icol][0] = b;
      row_mem[irow & 3][icol][1] = g;
      row_mem[irow & 3][icol][2] = r;
      icol++;
      if (icol >= fw) begin
        icol = 0;
        irow++;
      end
      inc++;
      if (inc >= outc + fw + 2) emit = 1;
    end else if (inc >= total && outc < total) begin
      emit = 1;
    end
    if (!emit) return 0;
    sum = '{0, 0, 0};
    for (int dy = -1; dy <= 1; dy++) begin
      rr = mirror(orow, dy, fh) & 3;
      for (int dx = -1; dx <= 1; dx++) begin
        cc = mirror(ocol, dx, fw);
        k = kern[dy+1][16*(dx+1) +: 16];
        for (int ch = 0; ch < 3; ch++)
          sum[ch] += longint'(k) * longint'(row_mem[rr][cc][ch]);
      end
    end
    res.b = round_clip(sum[0]);
    res.g = round_clip(sum[1]);
    res.r = round_clip(sum[2]);
    res.last = (outc + 1 == total);
    ocol++;
    if (ocol >= fw) begin
      ocol = 0;
      orow++;
    end
    if (res.last) begin
      icol = 0; irow = 0; ocol = 0; orow = 0;
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet_in) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one word, wait for it to be taken, then predict
  task automatic send_word(logic m, logic [7:0] b, g, r, chk_t chk, pix_result_t typed);
    int gap;
    bit got;
    bit rdy;
    pix_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    pix_blue <= b;
    pix_green <= g;
    pix_red <= r;
    // ready is sampled mid-cycle, where it holds its value for the coming edge
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    got = filter_word(m, b, g, r, res);
    words_sent++;
    if (chk == CHK_TYPED) pending_pix.push_back(typed);
    else if (chk == CHK_MODEL && got) pending_pix.push_back(res);
    if ($urandom_range(0, 199) == 0) quiet_in = !quiet_in;
  endtask

  // Let the pipeline empty before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [47:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_cfg(idx, d);
  endtask

  task automatic rand_word(logic m, chk_t chk);
    logic [7:0] c [3];
    pix_result_t none;
    none = '{8'd0, 8'd0, 8'd0, 1'b0};
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 9))
        0: c[i] = 8'd0;
        1: c[i] = 8'd255;
        default: c[i] = $urandom_range(0, 255);
      endcase
    send_word(m, c[0], c[1], c[2], chk, none);
  endtask

  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] v;
    for (int i = 0; i < 3; i++)
      case ($urandom_range(0, 5))
        0: v[16*i +: 16] = {$urandom} & 16'hFFFF;
        1: v[16*i +: 16] = 16'h0;
        2: v[16*i +: 16] = 16'h0100;
        default: v[16*i +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
      endcase
    return v;
  endfunction

  // Result checker and receive-side stalls
  int stall_left = 0;
  bit quiet_out = 1'b0;
  pix_result_t want;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL conv3x3_rgb_reflect_clamp");
      $finish;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_pix.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: b %0d g %0d r %0d last %0d",
                     out_blue, out_green, out_red, frame_last);
        end else begin
          want = pending_pix.pop_front();
          if (want.b !== out_blue || want.g !== out_green || want.r !== out_red ||
              want.last !== frame_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected b %0d g %0d r %0d last %0d, got %0d %0d %0d %0d",
                       want.b, want.g, want.r, want.last,
                       out_blue, out_green, out_red, frame_last);
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet_out && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
        if ($urandom_range(0, 299) == 0) quiet_out = !quiet_out;
      end
    end
  end

  step_row_t steps [$];

  function automatic void add_cfg(reg_idx_t idx, logic [47:0] d);
    step_row_t s;
    s = '{1'b1, idx, d, MODE_PIXEL, 8'd0, 8'd0, 8'd0, CHK_NONE, '{8'd0, 8'd0, 8'd0, 1'b0}};
    steps.push_back(s);
  endfunction

  function automatic void add_word(logic m, logic [7:0] b, g, r, chk_t chk,
                                   pix_result_t res);
    step_row_t s;
    s = '{1'b0, REG_WIDTH, 48'h0, m, b, g, r, chk, res};
    steps.push_back(s);
  endfunction

  initial begin
    int unsigned w, h, n;
    bit broken, big_done, force_size, big_now;
    pix_result_t z;
    z = '{8'd0, 8'd0, 8'd0, 1'b0};

    // Identity kernel on a 2x2 frame: the output is the input
    add_cfg(REG_WIDTH, 48'd0);
    add_cfg(REG_HEIGHT, 48'd1);
    add_cfg(REG_SPARE_LO, '1);
    add_word(MODE_DRAIN, 8'h12, 8'h34, 8'h56, CHK_NONE, z);
    add_word(MODE_PIXEL, 8'hFF, 8'h00, 8'h80, CHK_NONE, z);
    add_word(MODE_PIXEL, 8'h00, 8'hFF, 8'h01, CHK_NONE, z);
    add_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00, CHK_NONE, z);
    add_word(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, z);
    add_word(MODE_PIXEL, 8'h00, 8'h00, 8'h00, CHK_TYPED, '{8'hFF, 8'h00, 8'h80, 1'b0});
    add_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00, CHK_TYPED, '{8'h00, 8'hFF, 8'h01, 1'b0});
    add_word(MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF, CHK_TYPED, '{8'hFF, 8'hFF, 8'hFF, 1'b0});
    // a pixel after the frame end acts as a drain tick
    add_word(MODE_PIXEL, 8'hAA, 8'h55, 8'hAA, CHK_TYPED, '{8'h00, 8'h00, 8'h00, 1'b1});
    add_word(MODE_DRAIN, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, z);
    // Largest positive kernel saturates the nonzero channels high
    add_cfg(REG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    add_cfg(REG_COEF_MID, 48'h7FFF_7FFF_7FFF);
    add_cfg(REG_COEF_BOT, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 4; i++) add_word(MODE_PIXEL, 8'hFF, 8'h01, 8'h00, CHK_MODEL, z);
    for (int i = 0; i < 3; i++) add_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00, CHK_MODEL, z);
    // Most negative kernel saturates low
    add_cfg(REG_COEF_TOP, 48'h8000_8000_8000);
    add_cfg(REG_COEF_MID, 48'h8000_8000_8000);
    add_cfg(REG_COEF_BOT, 48'h8000_8000_8000);
    for (int i = 0; i < 4; i++) add_word(MODE_PIXEL, 8'hFF, 8'hFF, 8'h7F, CHK_MODEL, z);
    for (int i = 0; i < 3; i++) add_word(MODE_DRAIN, 8'h00, 8'h00, 8'h00, CHK_MODEL, z);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        settle();
        cfg_write(steps[i].idx, steps[i].data);
      end else begin
        send_word(steps[i].m, steps[i].b, steps[i].g, steps[i].r, steps[i].chk,
                  steps[i].res);
      end
    end

    // Random frames
    words_sent = 0;
    big_done = 0;
    force_size = 0;
    while (words_sent < RANDOM_WORDS) begin
      settle();
      broken = ($urandom_range(0, 6) == 0);
      big_now = 0;
      if (force_size || $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 19))
          0: w = $urandom_range(0, 1);
          1: w = $urandom_range(7, 24);
          2: w = (!big_done && words_sent > 600) ? 4095 : 3;
          default: w = $urandom_range(2, 6);
        endcase
        cfg_write(REG_WIDTH, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000 | 48'(w));
        case ($urandom_range(0, 19))
          0: h = $urandom_range(0, 1);
          1: h = broken ? 4095 : $urandom_range(6, 10);
          default: h = $urandom_range(2, 5);
        endcase
        if (w == 4095) begin
          // widest row: only the start of the frame, enough for a few results
          h = 2;
          big_done = 1;
          big_now = 1;
          broken = 1;
        end
        cfg_write(REG_HEIGHT, 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000 | 48'(h));
      end
      force_size = 0;
      if ($urandom_range(0, 1) == 0) cfg_write(REG_COEF_TOP, rand_kernel_row());
      if ($urandom_range(0, 1) == 0) cfg_write(REG_COEF_MID, rand_kernel_row());
      if ($urandom_range(0, 1) == 0) cfg_write(REG_COEF_BOT, rand_kernel_row());
      if ($urandom_range(0, 9) == 0)
        cfg_write(reg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), rand_kernel_row());

      n = broken ? $urandom_range(1, fw * 3) : fw * fh;
      if (big_now) n = fw + $urandom_range(2, 40);
      if (n > fw * fh) n = fw * fh - 1;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) rand_word(MODE_DRAIN, CHK_MODEL);
        rand_word(MODE_PIXEL, CHK_MODEL);
      end
      if (broken) begin
        force_size = 1;
      end else begin
        // release the tail; some ticks are pixels past the frame end
        for (int i = 0; i < fw; i++)
          rand_word($urandom_range(0, 4) == 0 ? MODE_PIXEL : MODE_DRAIN, CHK_MODEL);
        rand_word(MODE_DRAIN, CHK_MODEL);
        if ($urandom_range(0, 4) == 0) rand_word(MODE_DRAIN, CHK_MODEL);
      end
    end

    settle();
    if (mismatches == 0 && pending_pix.size() == 0)
      $display("PASS conv3x3_rgb_reflect_clamp");
    else
      $display("FAIL conv3x3_rgb_reflect_clamp");
    $finish;
  end

endmodule
